/* hw/rtl/bclru_pkg.sv */
package bclru_pkg;

  localparam int ENTRIES     = 32;
  localparam int BUCKETS     = 13;
  localparam int IDX_W       = 5;
  localparam int BKT_W       = 4;
  localparam int CNT_W       = 8;
  localparam int STAMP_W     = 32;
  localparam int DEV_W       = 8;
  localparam int BLK_W       = 32;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;

  // Reciprocal of BUCKETS: floor(x / 13) = (x * BKT_RECIP) >> BKT_RSHIFT for 32-bit x
  localparam logic [BLK_W-1:0] BKT_RECIP  = 32'h4EC4_EC4F;
  localparam int               BKT_RSHIFT = 34;

  typedef enum logic [OP_W-1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_DECIDE,
    S_SEARCH,
    S_UPDATE,
    S_OUT
  } state_t;

  // Payloads
  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block_number;
    logic [IDX_W-1:0]   entry_index;
    logic [STAMP_W-1:0] now_tick;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic             hit;
    logic             needs_read;
    logic [ST_W-1:0]  status;
  } rsp_t;

  // Token that travels down the cell chain during a scan
  typedef struct packed {
    logic               hit_found;
    logic [IDX_W-1:0]   hit_idx;
    logic               vic_found;
    logic [IDX_W-1:0]   vic_idx;
    logic [STAMP_W-1:0] vic_stamp;
  } tok_t;

  // Write command broadcast to all cells
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic               set_tag;
    logic [DEV_W-1:0]   device;
    logic [BLK_W-1:0]   block_number;
    logic [BKT_W-1:0]   bucket;
    logic               set_cnt;
    logic [CNT_W-1:0]   cnt;
    logic               set_stamp;
    logic [STAMP_W-1:0] stamp;
    logic               set_valid;
    logic               valid;
  } wr_t;

  // Next bucket with wraparound
  function automatic logic [BKT_W-1:0] bkt_inc(input logic [BKT_W-1:0] b);
    logic [BKT_W-1:0] r;
    r = (b == BKT_W'(BUCKETS - 1)) ? '0 : b + 1'b1;
    return r;
  endfunction

endpackage

/* hw/rtl/bclru_if.sv */
interface bclru_req_if;
  import bclru_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface bclru_rsp_if;
  import bclru_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/bclru_mod13.sv */
module bclru_mod13
  import bclru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BLK_W-1:0] value,
  output logic             done,
  output logic [BKT_W-1:0] rem
);

  // Two stages: register value * reciprocal, then rem = value - quotient * BUCKETS.
  // value must hold from the cycle after start until done.
  logic               go1_r, go2_r;
  logic [2*BLK_W-1:0] prod_r;
  logic [BLK_W-1:0]   quo;
  logic [BLK_W-1:0]   diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go1_r <= 1'b0;
      go2_r <= 1'b0;
    end else begin
      go1_r <= start;
      go2_r <= go1_r;
    end
    prod_r <= (2*BLK_W)'(value) * (2*BLK_W)'(BKT_RECIP);
  end

  // Take the quotient and subtract its multiple
  always_comb begin
    quo  = BLK_W'(prod_r >> BKT_RSHIFT);
    diff = value - quo * BLK_W'(BUCKETS);
  end

  assign done = go2_r;
  assign rem  = BKT_W'(diff);

endmodule

/* hw/rtl/bclru_cell.sv */
module bclru_cell
  import bclru_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] my_idx,
  input  wr_t              wr,
  // scan request, broadcast
  input  logic [DEV_W-1:0] q_dev,
  input  logic [BLK_W-1:0] q_blk,
  input  logic [BKT_W-1:0] q_bkt,
  input  logic             step,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  // addressed read
  output logic [CNT_W-1:0]   cnt,
  output logic               valid
);

  logic [DEV_W-1:0]   dev_r;
  logic [BLK_W-1:0]   blk_r;
  logic [BKT_W-1:0]   bkt_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               valid_r;
  tok_t               tok_r, tok_nxt;
  logic               sel;

  assign sel = wr.en && (wr.idx == my_idx);

  // Hold entry state; write when addressed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= '0;
      blk_r   <= '0;
      bkt_r   <= '0;
      cnt_r   <= '0;
      stamp_r <= '0;
      valid_r <= 1'b0;
    end else if (sel) begin
      if (wr.set_tag) begin
        dev_r <= wr.device;
        blk_r <= wr.block_number;
        bkt_r <= wr.bucket;
      end
      if (wr.set_cnt)   cnt_r   <= wr.cnt;
      if (wr.set_stamp) stamp_r <= wr.stamp;
      if (wr.set_valid) valid_r <= wr.valid;
    end
  end

  // Merge own entry into the passing token
  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.hit_found && dev_r == q_dev && blk_r == q_blk) begin
      tok_nxt.hit_found = 1'b1;
      tok_nxt.hit_idx   = my_idx;
    end
    if (cnt_r == '0 && bkt_r == q_bkt &&
        (!tok_in.vic_found || stamp_r < tok_in.vic_stamp)) begin
      tok_nxt.vic_found = 1'b1;
      tok_nxt.vic_idx   = my_idx;
      tok_nxt.vic_stamp = stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) tok_r <= tok_nxt;
  end

  assign tok_out = tok_r;
  assign cnt     = cnt_r;
  assign valid   = valid_r;

endmodule

/* hw/rtl/block_cache_lru_tags.sv */
// Channel | Dir | Fields
// in_     | in  | opcode, device, block_number, entry_index, now_tick
// out_    | out | result_index, hit, needs_read, status
//
// Get: block mod 13 by reciprocal multiply, then per searched bucket a scan of the token
// through the 32-cell chain plus a decide state (hit check rides the first pass) and a
// search state between buckets, up to 13 buckets on a miss; then an update state.
// Release/pin/unpin go straight to the update state. Reset clears all entries.
// One transaction in flight; the result waits in the output register while
// out_ready is low.
module block_cache_lru_tags
  import bclru_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  bclru_req_if.sink  in_ch,
  bclru_rsp_if.source out_ch
);

  state_t state_r, state_nxt;
  req_t   req_r;
  rsp_t   rsp_r, rsp_nxt;
  logic [BKT_W-1:0] home_r, cur_bkt_r, cur_bkt_nxt;
  logic [BKT_W-1:0] tries_r, tries_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic             first_r, first_nxt;
  logic             hitf_r, hitf_nxt;
  logic [IDX_W-1:0] hidx_r, hidx_nxt;
  logic             vicf_r, vicf_nxt;
  logic [IDX_W-1:0] vidx_r, vidx_nxt;

  logic             mod_start, mod_done;
  logic [BKT_W-1:0] mod_rem;
  logic             step;
  wr_t              wr;

  tok_t               tok [ENTRIES+1];
  logic [CNT_W-1:0]   c_cnt   [ENTRIES];
  logic               c_valid [ENTRIES];
  logic [IDX_W-1:0]   a_idx;
  logic [CNT_W-1:0]   a_cnt;
  logic               a_valid;

  bclru_mod13 u_mod (
    .clk, .rst_n, .start(mod_start), .value(req_r.block_number),
    .done(mod_done), .rem(mod_rem)
  );

  assign tok[0] = '0;

  // Cell chain: token shifts one cell per cycle while in S_SCAN and holds otherwise
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    bclru_cell u_cell (
      .clk, .rst_n, .my_idx(IDX_W'(g)), .wr,
      .q_dev(req_r.device), .q_blk(req_r.block_number), .q_bkt(cur_bkt_r),
      .step, .tok_in(tok[g]), .tok_out(tok[g+1]),
      .cnt(c_cnt[g]), .valid(c_valid[g])
    );
  end

  assign a_cnt   = c_cnt[a_idx];
  assign a_valid = c_valid[a_idx];
  assign step    = (state_r == S_SCAN);

  // Next state
  always_comb begin
    state_nxt   = state_r;
    cur_bkt_nxt = cur_bkt_r;
    tries_nxt   = tries_r;
    pos_nxt     = pos_r;
    first_nxt   = first_r;
    hitf_nxt    = hitf_r;
    hidx_nxt    = hidx_r;
    vicf_nxt    = vicf_r;
    vidx_nxt    = vidx_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.payload.opcode == OP_GET) state_nxt = S_MOD;
          else state_nxt = S_UPDATE;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          cur_bkt_nxt = mod_rem;
          tries_nxt   = '0;
          pos_nxt     = '0;
          first_nxt   = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r == 6'(ENTRIES)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (first_r) begin
          hitf_nxt = tok[ENTRIES].hit_found;
          hidx_nxt = tok[ENTRIES].hit_idx;
        end
        vicf_nxt = tok[ENTRIES].vic_found;
        vidx_nxt = tok[ENTRIES].vic_idx;
        first_nxt = 1'b0;
        if ((first_r && tok[ENTRIES].hit_found) || tok[ENTRIES].vic_found ||
            tries_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt = S_UPDATE;
        end else state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        cur_bkt_nxt = bkt_inc(cur_bkt_r);
        tries_nxt   = tries_r + 1'b1;
        pos_nxt     = '0;
        state_nxt   = S_SCAN;
      end
      S_UPDATE: state_nxt = S_OUT;
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and entry updates
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
    mod_start   = (state_r == S_IDLE) && in_ch.valid &&
                  (in_ch.payload.opcode == OP_GET);
    wr          = '0;
    rsp_nxt     = rsp_r;
    a_idx       = hitf_r ? hidx_r : vidx_r;
    if (req_r.opcode != OP_GET) a_idx = req_r.entry_index;
    if (state_r == S_UPDATE) begin
      wr.idx          = a_idx;
      wr.device       = req_r.device;
      wr.block_number = req_r.block_number;
      wr.bucket       = home_r;
      wr.stamp        = req_r.now_tick;
      wr.valid        = 1'b1;
      rsp_nxt.result_index = a_idx;
      rsp_nxt.hit          = 1'b0;
      rsp_nxt.needs_read   = 1'b0;
      rsp_nxt.status       = ST_OK;
      case (req_r.opcode)
        OP_GET: begin
          if (hitf_r) begin
            wr.en        = 1'b1;
            wr.set_cnt   = 1'b1;
            wr.cnt       = (a_cnt == '1) ? a_cnt : a_cnt + 1'b1;
            wr.set_stamp = 1'b1;
            wr.set_valid = 1'b1;
            rsp_nxt.hit        = 1'b1;
            rsp_nxt.needs_read = !a_valid;
          end else if (vicf_r) begin
            wr.en        = 1'b1;
            wr.set_tag   = 1'b1;
            wr.set_cnt   = 1'b1;
            wr.cnt       = CNT_W'(1);
            wr.set_stamp = 1'b1;
            wr.set_valid = 1'b1;
            rsp_nxt.needs_read = 1'b1;
          end else begin
            rsp_nxt.result_index = '0;
            rsp_nxt.status       = ST_NO_FREE;
          end
        end
        OP_PIN: begin
          wr.en      = 1'b1;
          wr.set_cnt = 1'b1;
          wr.cnt     = (a_cnt == '1) ? a_cnt : a_cnt + 1'b1;
        end
        default: begin
          wr.en        = 1'b1;
          wr.set_cnt   = 1'b1;
          wr.cnt       = (a_cnt == '0) ? a_cnt : a_cnt - 1'b1;
          wr.set_stamp = (req_r.opcode == OP_RELEASE);
          if (a_cnt == '0) rsp_nxt.status = ST_UNDERFLOW;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
      hitf_r  <= 1'b0;
      vicf_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      hitf_r  <= (state_r == S_IDLE) ? 1'b0 : hitf_nxt;
      vicf_r  <= (state_r == S_IDLE) ? 1'b0 : vicf_nxt;
    end
    if (in_ch.valid && in_ch.ready) req_r <= in_ch.payload;
    if (state_r == S_MOD && mod_done) home_r <= mod_rem;
    cur_bkt_r <= cur_bkt_nxt;
    tries_r   <= tries_nxt;
    pos_r     <= pos_nxt;
    hidx_r    <= hidx_nxt;
    vidx_r    <= vidx_nxt;
    rsp_r     <= rsp_nxt;
  end

  assign out_ch.valid   = (state_r == S_OUT);
  assign out_ch.payload = rsp_r;

  // Checks
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("accept while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
    else $error("result dropped");
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.payload.hit |-> out_ch.payload.status == ST_OK)
    else $error("hit with bad status");
  a_free_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.payload.status == ST_NO_FREE |->
    out_ch.payload.result_index == '0 && !out_ch.payload.needs_read)
    else $error("no-free result malformed");

endmodule
